// ===== sv/c6502_pkg.sv =====
// ============================================================================
// c6502_pkg: shared types and constants of the 6502 execute unit
// Operation codes, flag masks, the classified operation record.
// ============================================================================
package c6502_pkg;

  localparam int unsigned ActW   = 7;
  localparam int unsigned QDepth = 2;

  localparam logic [7:0] SpReset    = 8'hFD;
  localparam logic [7:0] StatReset  = 8'h24;
  localparam logic [7:0] StackPage  = 8'h01;
  localparam logic [7:0] FlagMask   = 8'hCF;

  typedef enum logic [6:0] {
    ACT_NOP = 7'd0, ACT_LDA = 7'd1, ACT_LDX = 7'd2, ACT_LDY = 7'd3, ACT_LAX = 7'd4,
    ACT_LAS = 7'd5, ACT_STA = 7'd6, ACT_STX = 7'd7, ACT_STY = 7'd8, ACT_SAX = 7'd9,
    ACT_AHX = 7'd10, ACT_TAS = 7'd11, ACT_SHX = 7'd12, ACT_SHY = 7'd13, ACT_TAX = 7'd14,
    ACT_TAY = 7'd15, ACT_TSX = 7'd16, ACT_TXA = 7'd17, ACT_TXS = 7'd18, ACT_TYA = 7'd19,
    ACT_AND = 7'd20, ACT_ORA = 7'd21, ACT_EOR = 7'd22, ACT_ADC = 7'd23, ACT_SBC = 7'd24,
    ACT_CMP = 7'd25, ACT_CPX = 7'd26, ACT_CPY = 7'd27, ACT_BIT = 7'd28,
    ACT_ASL_A = 7'd29, ACT_LSR_A = 7'd30, ACT_ROL_A = 7'd31, ACT_ROR_A = 7'd32,
    ACT_ASL_M = 7'd33, ACT_LSR_M = 7'd34, ACT_ROL_M = 7'd35, ACT_ROR_M = 7'd36,
    ACT_INC = 7'd37, ACT_DEC = 7'd38, ACT_INX = 7'd39, ACT_INY = 7'd40,
    ACT_DEX = 7'd41, ACT_DEY = 7'd42, ACT_BCC = 7'd43, ACT_BCS = 7'd44,
    ACT_BEQ = 7'd45, ACT_BNE = 7'd46, ACT_BMI = 7'd47, ACT_BPL = 7'd48,
    ACT_BVC = 7'd49, ACT_BVS = 7'd50, ACT_CLC = 7'd51, ACT_SEC = 7'd52,
    ACT_CLI = 7'd53, ACT_SEI = 7'd54, ACT_CLD = 7'd55, ACT_SED = 7'd56,
    ACT_CLV = 7'd57, ACT_PHA = 7'd58, ACT_PHP = 7'd59, ACT_PLA = 7'd60,
    ACT_PLP = 7'd61, ACT_SLO = 7'd62, ACT_RLA = 7'd63, ACT_SRE = 7'd64,
    ACT_RRA = 7'd65, ACT_DCP = 7'd66, ACT_ISC = 7'd67, ACT_ANC = 7'd68,
    ACT_ALR = 7'd69, ACT_ARR = 7'd70, ACT_AXS = 7'd71, ACT_XAA = 7'd72,
    ACT_STP = 7'd73, ACT_UNOP = 7'd74, ACT_USBC = 7'd75
  } act_t;

  // operation record as classified by the front end
  typedef struct packed {
    act_t       act;
    logic [7:0] operand;
    logic [7:0] hi1;       // addr_page + 1
    logic [7:0] page;
    logic       crossed;
    logic       writes;    // operation writes memory
  } op_t;

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] xr;
    logic [7:0] yr;
    logic [7:0] sp;
    logic [7:0] status;
    logic       we;
    logic [7:0] wd;
    logic [7:0] wp;
    logic       br;
    logic       halted;
  } res_t;

endpackage

// ===== sv/c6502_if.sv =====
// ============================================================================
// c6502 channel interfaces
// Valid/ready channels for operation requests and results.
// ============================================================================
interface c6502_in_if;
  logic       valid;
  logic       ready;
  logic [6:0] action;
  logic [7:0] operand;
  logic [7:0] addr_page;
  logic       page_crossed;
  modport source (output valid, action, operand, addr_page, page_crossed, input ready);
  modport sink (input valid, action, operand, addr_page, page_crossed, output ready);
endinterface

interface c6502_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] acc_out;
  logic [7:0] xreg_out;
  logic [7:0] yreg_out;
  logic [7:0] stack_ptr_out;
  logic [7:0] status_out;
  logic       write_enable;
  logic [7:0] write_data;
  logic [7:0] write_page;
  logic       branch_taken;
  logic       halted;
  modport source (output valid, acc_out, xreg_out, yreg_out, stack_ptr_out, status_out,
                  write_enable, write_data, write_page, branch_taken, halted,
                  input ready);
  modport sink (input valid, acc_out, xreg_out, yreg_out, stack_ptr_out, status_out,
                write_enable, write_data, write_page, branch_taken, halted,
                output ready);
endinterface

// ===== sv/c6502_front.sv =====
// ============================================================================
// c6502_front: request intake and classification
// Decodes the operation code and fills a two-entry queue.
// ============================================================================
module c6502_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [6:0]        in_action,
  input  logic [7:0]        in_operand,
  input  logic [7:0]        in_addr_page,
  input  logic              in_page_crossed,
  output logic              q_valid,
  input  logic              q_pop,
  output c6502_pkg::op_t    q_head
);
  c6502_pkg::op_t q_r [c6502_pkg::QDepth];
  logic       wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  c6502_pkg::op_t cls;
  logic push, pop;

  // classify: codes past the list run as NOP
  always_comb begin
    cls.act     = (in_action > 7'd75) ? c6502_pkg::ACT_NOP : c6502_pkg::act_t'(in_action);
    cls.operand = in_operand;
    cls.hi1     = in_addr_page + 8'd1;
    cls.page    = in_addr_page;
    cls.crossed = in_page_crossed;
    case (cls.act)
      c6502_pkg::ACT_STA, c6502_pkg::ACT_STX, c6502_pkg::ACT_STY, c6502_pkg::ACT_SAX,
      c6502_pkg::ACT_AHX, c6502_pkg::ACT_TAS, c6502_pkg::ACT_SHX, c6502_pkg::ACT_SHY,
      c6502_pkg::ACT_ASL_M, c6502_pkg::ACT_LSR_M, c6502_pkg::ACT_ROL_M,
      c6502_pkg::ACT_ROR_M, c6502_pkg::ACT_INC, c6502_pkg::ACT_DEC,
      c6502_pkg::ACT_PHA, c6502_pkg::ACT_PHP, c6502_pkg::ACT_SLO, c6502_pkg::ACT_RLA,
      c6502_pkg::ACT_SRE, c6502_pkg::ACT_RRA, c6502_pkg::ACT_DCP,
      c6502_pkg::ACT_ISC: cls.writes = 1'b1;
      default: cls.writes = 1'b0;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_head   = q_r[rd_ptr_r];

  // queue pointers
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= cls;
  end
endmodule

// ===== sv/c6502_back.sv =====
// ============================================================================
// c6502_back: register file, ALU and result register
// One queued op per cycle unless a result is held; one output register.
// ============================================================================
module c6502_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_pop,
  input  c6502_pkg::op_t q_head,
  output logic           res_valid,
  input  logic           res_ready,
  output c6502_pkg::res_t res
);
  logic [7:0] a_r, a_nxt, x_r, x_nxt, y_r, y_nxt, s_r, s_nxt, f_r, f_nxt;
  logic       stop_r, stop_nxt;
  logic       vld_r;
  c6502_pkg::res_t res_r, res_nxt;
  logic       we, br;
  logic [7:0] wd, wp, m, t, ax;
  logic [8:0] sum;
  logic       c;

  assign q_pop     = q_valid && (!vld_r || res_ready);
  assign res_valid = vld_r;
  assign res       = res_r;

  // execute
  always_comb begin
    a_nxt = a_r; x_nxt = x_r; y_nxt = y_r; s_nxt = s_r; f_nxt = f_r;
    stop_nxt = stop_r;
    we = 1'b0; br = 1'b0; wd = 8'h00; wp = q_head.page;
    m  = q_head.operand;
    c  = f_r[0];
    ax = a_r & x_r;
    t  = 8'h00;
    sum = 9'h000;
    if (!stop_r) begin
      we = q_head.writes;
      // memory side result for read-modify-write forms
      case (q_head.act)
        c6502_pkg::ACT_ASL_M, c6502_pkg::ACT_SLO: begin
          t = {m[6:0], 1'b0}; f_nxt[0] = m[7];
        end
        c6502_pkg::ACT_ROL_M, c6502_pkg::ACT_RLA: begin
          t = {m[6:0], c}; f_nxt[0] = m[7];
        end
        c6502_pkg::ACT_LSR_M, c6502_pkg::ACT_SRE: begin
          t = {1'b0, m[7:1]}; f_nxt[0] = m[0];
        end
        c6502_pkg::ACT_ROR_M, c6502_pkg::ACT_RRA: begin
          t = {c, m[7:1]}; f_nxt[0] = m[0];
        end
        c6502_pkg::ACT_INC, c6502_pkg::ACT_ISC: t = m + 8'd1;
        c6502_pkg::ACT_DEC, c6502_pkg::ACT_DCP: t = m - 8'd1;
        default: t = m;
      endcase
      // main operation
      case (q_head.act)
        c6502_pkg::ACT_LDA, c6502_pkg::ACT_PLA: a_nxt = m;
        c6502_pkg::ACT_LDX: x_nxt = m;
        c6502_pkg::ACT_LDY: y_nxt = m;
        c6502_pkg::ACT_LAX: begin a_nxt = m; x_nxt = m; end
        c6502_pkg::ACT_LAS: begin
          a_nxt = m & s_r; x_nxt = m & s_r; s_nxt = m & s_r;
        end
        c6502_pkg::ACT_STA: wd = a_r;
        c6502_pkg::ACT_STX: wd = x_r;
        c6502_pkg::ACT_STY: wd = y_r;
        c6502_pkg::ACT_SAX: wd = ax;
        c6502_pkg::ACT_AHX: wd = ax & q_head.hi1;
        c6502_pkg::ACT_TAS: begin s_nxt = ax; wd = ax & q_head.hi1; end
        c6502_pkg::ACT_SHX: begin
          wd = x_r & q_head.hi1; if (q_head.crossed) wp = wd;
        end
        c6502_pkg::ACT_SHY: begin
          wd = y_r & q_head.hi1; if (q_head.crossed) wp = wd;
        end
        c6502_pkg::ACT_TAX: x_nxt = a_r;
        c6502_pkg::ACT_TAY: y_nxt = a_r;
        c6502_pkg::ACT_TSX: x_nxt = s_r;
        c6502_pkg::ACT_TXA: a_nxt = x_r;
        c6502_pkg::ACT_TXS: s_nxt = x_r;
        c6502_pkg::ACT_TYA: a_nxt = y_r;
        c6502_pkg::ACT_AND: a_nxt = a_r & m;
        c6502_pkg::ACT_ORA: a_nxt = a_r | m;
        c6502_pkg::ACT_EOR: a_nxt = a_r ^ m;
        c6502_pkg::ACT_ADC, c6502_pkg::ACT_RRA: begin
          wd = t;
          sum = {1'b0, a_r} + {1'b0, t} + {8'h00, f_nxt[0]};
          a_nxt = sum[7:0]; f_nxt[0] = sum[8];
          f_nxt[6] = ~(a_r[7] ^ t[7]) & (a_r[7] ^ sum[7]);
        end
        c6502_pkg::ACT_SBC, c6502_pkg::ACT_USBC, c6502_pkg::ACT_ISC: begin
          wd = t;
          sum = {1'b0, a_r} + {1'b0, ~t} + {8'h00, c};
          a_nxt = sum[7:0]; f_nxt[0] = sum[8];
          f_nxt[6] = (a_r[7] ^ t[7]) & (a_r[7] ^ sum[7]);
        end
        c6502_pkg::ACT_CMP, c6502_pkg::ACT_CPX, c6502_pkg::ACT_CPY,
        c6502_pkg::ACT_DCP, c6502_pkg::ACT_AXS: begin
          wd = t;
          case (q_head.act)
            c6502_pkg::ACT_CPX: sum = {1'b0, x_r} + {1'b0, ~t} + 9'd1;
            c6502_pkg::ACT_CPY: sum = {1'b0, y_r} + {1'b0, ~t} + 9'd1;
            c6502_pkg::ACT_AXS: sum = {1'b0, ax} + {1'b0, ~t} + 9'd1;
            default:            sum = {1'b0, a_r} + {1'b0, ~t} + 9'd1;
          endcase
          f_nxt[0] = sum[8];
          if (q_head.act == c6502_pkg::ACT_AXS) x_nxt = sum[7:0];
        end
        c6502_pkg::ACT_BIT: f_nxt[7:6] = m[7:6];
        c6502_pkg::ACT_ASL_A: begin a_nxt = {a_r[6:0], 1'b0}; f_nxt[0] = a_r[7]; end
        c6502_pkg::ACT_ROL_A: begin a_nxt = {a_r[6:0], c}; f_nxt[0] = a_r[7]; end
        c6502_pkg::ACT_LSR_A: begin a_nxt = {1'b0, a_r[7:1]}; f_nxt[0] = a_r[0]; end
        c6502_pkg::ACT_ROR_A: begin a_nxt = {c, a_r[7:1]}; f_nxt[0] = a_r[0]; end
        c6502_pkg::ACT_ASL_M, c6502_pkg::ACT_LSR_M, c6502_pkg::ACT_ROL_M,
        c6502_pkg::ACT_ROR_M, c6502_pkg::ACT_INC, c6502_pkg::ACT_DEC: wd = t;
        c6502_pkg::ACT_INX: x_nxt = x_r + 8'd1;
        c6502_pkg::ACT_INY: y_nxt = y_r + 8'd1;
        c6502_pkg::ACT_DEX: x_nxt = x_r - 8'd1;
        c6502_pkg::ACT_DEY: y_nxt = y_r - 8'd1;
        c6502_pkg::ACT_BCC: br = ~f_r[0];
        c6502_pkg::ACT_BCS: br = f_r[0];
        c6502_pkg::ACT_BEQ: br = f_r[1];
        c6502_pkg::ACT_BNE: br = ~f_r[1];
        c6502_pkg::ACT_BMI: br = f_r[7];
        c6502_pkg::ACT_BPL: br = ~f_r[7];
        c6502_pkg::ACT_BVC: br = ~f_r[6];
        c6502_pkg::ACT_BVS: br = f_r[6];
        c6502_pkg::ACT_CLC: f_nxt[0] = 1'b0;
        c6502_pkg::ACT_SEC: f_nxt[0] = 1'b1;
        c6502_pkg::ACT_CLI: f_nxt[2] = 1'b0;
        c6502_pkg::ACT_SEI: f_nxt[2] = 1'b1;
        c6502_pkg::ACT_CLD: f_nxt[3] = 1'b0;
        c6502_pkg::ACT_SED: f_nxt[3] = 1'b1;
        c6502_pkg::ACT_CLV: f_nxt[6] = 1'b0;
        c6502_pkg::ACT_PHA: begin wd = a_r; wp = c6502_pkg::StackPage; s_nxt = s_r - 8'd1; end
        c6502_pkg::ACT_PHP: begin
          wd = f_r | 8'h30; wp = c6502_pkg::StackPage; s_nxt = s_r - 8'd1;
        end
        c6502_pkg::ACT_PLP: f_nxt = m & c6502_pkg::FlagMask;
        c6502_pkg::ACT_SLO: begin wd = t; a_nxt = a_r | t; end
        c6502_pkg::ACT_RLA: begin wd = t; a_nxt = a_r & t; end
        c6502_pkg::ACT_SRE: begin wd = t; a_nxt = a_r ^ t; end
        c6502_pkg::ACT_ANC: begin a_nxt = a_r & m; f_nxt[0] = a_r[7] & m[7]; end
        c6502_pkg::ACT_ALR: begin
          a_nxt = {1'b0, a_r[7:1] & m[7:1]};
          f_nxt[0] = a_r[0] & m[0];
        end
        c6502_pkg::ACT_ARR: begin
          a_nxt = {c, a_r[7:1] & m[7:1]};
          f_nxt[0] = a_nxt[6]; f_nxt[6] = a_nxt[6] ^ a_nxt[5];
        end
        c6502_pkg::ACT_STP: stop_nxt = 1'b1;
        default: ;
      endcase
      if (q_head.act == c6502_pkg::ACT_PLA || q_head.act == c6502_pkg::ACT_PLP)
        s_nxt = s_r + 8'd1;
      // N and Z updates
      case (q_head.act)
        c6502_pkg::ACT_LDA, c6502_pkg::ACT_LAX, c6502_pkg::ACT_LAS, c6502_pkg::ACT_TAX,
        c6502_pkg::ACT_TXA, c6502_pkg::ACT_TYA, c6502_pkg::ACT_AND, c6502_pkg::ACT_ORA,
        c6502_pkg::ACT_EOR, c6502_pkg::ACT_ADC, c6502_pkg::ACT_SBC, c6502_pkg::ACT_USBC,
        c6502_pkg::ACT_ASL_A, c6502_pkg::ACT_LSR_A, c6502_pkg::ACT_ROL_A,
        c6502_pkg::ACT_ROR_A, c6502_pkg::ACT_PLA, c6502_pkg::ACT_SLO, c6502_pkg::ACT_RLA,
        c6502_pkg::ACT_SRE, c6502_pkg::ACT_RRA, c6502_pkg::ACT_ISC, c6502_pkg::ACT_ANC,
        c6502_pkg::ACT_ALR, c6502_pkg::ACT_ARR: begin
          f_nxt[7] = a_nxt[7]; f_nxt[1] = (a_nxt == 8'h00);
        end
        c6502_pkg::ACT_LDX, c6502_pkg::ACT_TSX, c6502_pkg::ACT_INX, c6502_pkg::ACT_DEX: begin
          f_nxt[7] = x_nxt[7]; f_nxt[1] = (x_nxt == 8'h00);
        end
        c6502_pkg::ACT_LDY, c6502_pkg::ACT_TAY, c6502_pkg::ACT_INY, c6502_pkg::ACT_DEY: begin
          f_nxt[7] = y_nxt[7]; f_nxt[1] = (y_nxt == 8'h00);
        end
        c6502_pkg::ACT_ASL_M, c6502_pkg::ACT_LSR_M, c6502_pkg::ACT_ROL_M,
        c6502_pkg::ACT_ROR_M, c6502_pkg::ACT_INC, c6502_pkg::ACT_DEC: begin
          f_nxt[7] = t[7]; f_nxt[1] = (t == 8'h00);
        end
        c6502_pkg::ACT_CMP, c6502_pkg::ACT_CPX, c6502_pkg::ACT_CPY,
        c6502_pkg::ACT_DCP, c6502_pkg::ACT_AXS: begin
          f_nxt[7] = sum[7]; f_nxt[1] = (sum[7:0] == 8'h00);
        end
        c6502_pkg::ACT_BIT: f_nxt[1] = ((a_r & m) == 8'h00);
        default: ;
      endcase
    end
    if (!we) begin wd = 8'h00; wp = 8'h00; end
    res_nxt.acc    = a_nxt;
    res_nxt.xr     = x_nxt;
    res_nxt.yr     = y_nxt;
    res_nxt.sp     = s_nxt;
    res_nxt.status = (f_nxt & c6502_pkg::FlagMask) | 8'h20;
    res_nxt.we     = we;
    res_nxt.wd     = wd;
    res_nxt.wp     = wp;
    res_nxt.br     = br;
    res_nxt.halted = stop_nxt;
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= 8'h00; x_r <= 8'h00; y_r <= 8'h00;
      s_r <= c6502_pkg::SpReset; f_r <= c6502_pkg::StatReset & c6502_pkg::FlagMask;
      stop_r <= 1'b0; vld_r <= 1'b0;
    end else begin
      if (q_pop) begin
        a_r <= a_nxt; x_r <= x_nxt; y_r <= y_nxt; s_r <= s_nxt; f_r <= f_nxt;
        stop_r <= stop_nxt;
      end
      if (q_pop) vld_r <= 1'b1;
      else if (res_ready) vld_r <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (q_pop) res_r <= res_nxt;
  end
endmodule

// ===== sv/cpu6502_execute_unit.sv =====
// ============================================================================
// cpu6502_execute_unit: 6502 register and flag execute stage
// Binary-mode ALU with undocumented operations, queued front end.
// ============================================================================
// One request per cycle while results are taken: the front end classifies a
// request and places it in a two-entry queue; the back end executes the head
// into a result register. The request channel stalls only when the queue is
// full behind a held result.
module cpu6502_execute_unit (
  input logic        clk,
  input logic        rst_n,
  c6502_in_if.sink   in_ch,
  c6502_out_if.source out_ch
);
  logic           q_valid, q_pop;
  c6502_pkg::op_t q_head;
  c6502_pkg::res_t res;

  c6502_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_action(in_ch.action),
    .in_operand(in_ch.operand), .in_addr_page(in_ch.addr_page),
    .in_page_crossed(in_ch.page_crossed),
    .q_valid, .q_pop, .q_head
  );

  c6502_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_head,
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res
  );

  assign out_ch.acc_out       = res.acc;
  assign out_ch.xreg_out      = res.xr;
  assign out_ch.yreg_out      = res.yr;
  assign out_ch.stack_ptr_out = res.sp;
  assign out_ch.status_out    = res.status;
  assign out_ch.write_enable  = res.we;
  assign out_ch.write_data    = res.wd;
  assign out_ch.write_page    = res.wp;
  assign out_ch.branch_taken  = res.br;
  assign out_ch.halted        = res.halted;

  // status bit 5 is always set and B always clear
  a_status_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.status_out[5] && !out_ch.status_out[4]))
    else $error("status fixed bits wrong");

  // no write means zero data and page
  a_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.write_enable) |->
      (out_ch.write_data == 8'h00 && out_ch.write_page == 8'h00))
    else $error("write data without enable");

  // once halted, a newer result stays halted with no write
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && res.halted && out_ch.valid) |=> (res.halted && !res.we && !res.br))
    else $error("halt not sticky");
endmodule
